>>> rtl/rka_pkg.sv
// shared types, constants and codes for the redlich-kister activity block
package rka_pkg;

    localparam int MAX_COMPONENTS = 16;
    localparam int MAX_PAIRS      = 64;
    localparam int POLY_ORDERS    = 4;

    localparam int COMP_W  = 4;
    localparam int PAIR_W  = 6;
    localparam int ORD_W   = 2;
    localparam int COEF_AW = PAIR_W + ORD_W;
    localparam int FRAC_W  = 25;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 32;

    localparam int QDEPTH  = 4;
    localparam int QAW     = 2;

    localparam logic [FRAC_W-1:0] ONE_Q24 = 25'd16777216;

    // request modes
    localparam logic [1:0] MODE_COEF = 2'd0;
    localparam logic [1:0] MODE_FRAC = 2'd1;
    localparam logic [1:0] MODE_COMP = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    // result status
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_BAD = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_TEMP  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_TLT   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_PRESS = 3'd2;
    localparam logic [CFG_AW-1:0] REG_IRT   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_COMPS = 3'd4;
    localparam logic [CFG_AW-1:0] REG_PAIRS = 3'd5;

    typedef struct packed {
        logic [1:0]         mode;
        logic [PAIR_W-1:0]  pair_entry;
        logic [ORD_W-1:0]   poly_order;
        logic [COMP_W-1:0]  comp_first;
        logic [COMP_W-1:0]  comp_second;
        logic signed [31:0] coef_u;
        logic signed [31:0] coef_s;
        logic signed [31:0] coef_cp;
        logic signed [31:0] coef_v;
        logic [COMP_W-1:0]  component;
        logic [FRAC_W-1:0]  fraction;
    } in_item_t;

    typedef struct packed {
        logic [COMP_W-1:0]  result_component;
        logic signed [31:0] ln_gamma;
        logic [1:0]         status;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [1:0] op;
        in_item_t   item;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

>>> rtl/redlich_kister_activity.sv
// top level of the redlich-kister activity coefficient block
//
//  port group  direction  handshake        payload
//  s_*         in         s_valid/s_ready  in_item_t
//  m_*         out        m_valid/m_ready  out_item_t
//  cfg_*       in         cfg_we           cfg_addr, cfg_wdata
//
// coefficient load goes through the shared multiplier; fraction load writes the fraction store
// compute: for each component in use, every pair entry in use is walked,
//   11 products per pair entry through one 33x33 multiplier
// reset is synchronous, no clearing pass; unwritten store entries read as anything
// a four-deep queue lets requests in while results stall in the output register
module redlich_kister_activity (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  rka_pkg::in_item_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output rka_pkg::out_item_t          m_data,
    input  logic                        cfg_we,
    input  logic [rka_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [rka_pkg::CFG_DW-1:0]  cfg_wdata
);
    import rka_pkg::*;

    q_status_t q_status;
    cmd_t      q_cmd;
    cmd_t      q_head;
    logic      q_push;
    logic      q_pop;

    rka_front u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_status (q_status),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    rka_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .status   (q_status)
    );

    rka_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .q_head    (q_head),
        .q_status  (q_status),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

>>> rtl/rka_front.sv
// front end: accepts requests, drops unused codes, clamps fractions
module rka_front (
    input  logic              s_valid,
    output logic              s_ready,
    input  rka_pkg::in_item_t s_data,
    input  rka_pkg::q_status_t q_status,
    output logic              q_push,
    output rka_pkg::cmd_t     q_cmd
);
    import rka_pkg::*;

    always_comb begin
        s_ready = !q_status.full;
        q_push  = s_valid && !q_status.full && (s_data.mode != MODE_NONE);
        q_cmd.op   = s_data.mode;
        q_cmd.item = s_data;
        if (s_data.fraction > ONE_Q24) begin
            q_cmd.item.fraction = ONE_Q24;
        end
    end

endmodule

>>> rtl/rka_queue.sv
// short command queue between front and back
module rka_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  rka_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output rka_pkg::cmd_t      head,
    output rka_pkg::q_status_t status
);
    import rka_pkg::*;

    cmd_t           mem_reg [QDEPTH];
    logic [QAW-1:0] wr_reg;
    logic [QAW-1:0] rd_reg;
    logic [QAW:0]   cnt_reg;
    logic           do_push;
    logic           do_pop;

    assign status.full  = (cnt_reg == (QAW+1)'(QDEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;
    assign head    = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/rka_back.sv
// back end: coefficient correction, fraction store and ln gamma sequencer
module rka_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [rka_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [rka_pkg::CFG_DW-1:0]  cfg_wdata,
    input  rka_pkg::cmd_t               q_head,
    input  rka_pkg::q_status_t          q_status,
    output logic                        q_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output rka_pkg::out_item_t          m_data
);
    import rka_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_LD0  = 4'd2;
    localparam logic [3:0] S_LD1  = 4'd3;
    localparam logic [3:0] S_LD2  = 4'd4;
    localparam logic [3:0] S_LD3  = 4'd5;
    localparam logic [3:0] S_LD4  = 4'd6;
    localparam logic [3:0] S_FRW  = 4'd7;
    localparam logic [3:0] S_BAD  = 4'd8;
    localparam logic [3:0] S_PAIR = 4'd9;
    localparam logic [3:0] S_FIN0 = 4'd10;
    localparam logic [3:0] S_FIN1 = 4'd11;
    localparam logic [3:0] S_FIN2 = 4'd12;
    localparam logic [3:0] S_FIN3 = 4'd13;
    localparam logic [3:0] S_EMIT = 4'd14;

    localparam logic [4:0] CNT_LAST = 5'd24;
    localparam logic signed [32:0] ONE_S = 33'sd16777216;
    localparam logic signed [63:0] MAX32 = 64'sd2147483647;
    localparam logic signed [63:0] MIN32 = -64'sd2147483648;

    function automatic logic signed [32:0] sx29(input logic signed [28:0] v);
        return {{4{v[28]}}, v};
    endfunction

    function automatic logic signed [32:0] sx32(input logic signed [31:0] v);
        return {v[31], v};
    endfunction

    // config registers
    logic [19:0] temp_reg;
    logic [31:0] tlt_reg;
    logic [23:0] press_reg;
    logic [31:0] irt_reg;
    logic [4:0]  cin_reg;
    logic [6:0]  pin_reg;

    // control
    logic [3:0]        state_reg;
    logic [4:0]        cnt_reg;
    logic [PAIR_W-1:0] ip_reg;
    logic [COMP_W-1:0] j_reg;
    logic              m_valid_reg;

    // datapath
    cmd_t               cmd_reg;
    logic signed [32:0] opa;
    logic signed [32:0] opb;
    logic signed [65:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [28:0] r_reg [7];
    logic signed [32:0] c_reg [POLY_ORDERS];
    logic [FRAC_W-1:0]  fa_reg;
    logic [FRAC_W-1:0]  fb_reg;
    logic [63:0]        mag_reg;
    logic               neg_reg;
    logic [63:0]        hi_reg;
    logic [31:0]        res_reg;
    logic [1:0]         rst_reg;
    out_item_t          m_data_reg;

    // stores
    logic [31:0]       coef_mem [MAX_PAIRS*POLY_ORDERS];
    logic [7:0]        pm_mem [MAX_PAIRS];
    logic [FRAC_W-1:0] fr_mem [MAX_COMPONENTS];
    logic [31:0]       coef_rd_reg;
    logic [7:0]        pm_rd_reg;
    logic [FRAC_W-1:0] fr1_rd_reg;
    logic [FRAC_W-1:0] fr2_rd_reg;

    logic [4:0]         cm;
    logic [3:0]         sidx;
    logic               ph;
    logic [ORD_W-1:0]   ord_rd;
    logic [ORD_W-1:0]   ord_cap;
    logic               is_first;
    logic               is_second;
    logic               is_other;
    logic signed [32:0] fa_s;
    logic signed [32:0] fb_s;
    logic signed [32:0] d33;
    logic signed [32:0] om33;
    logic signed [32:0] cap_val;
    logic signed [65:0] sh8;
    logic signed [65:0] sh24;
    logic [2:0]         tgt;
    logic [31:0]        ld_sat;
    logic [63:0]        fin_sum;
    logic               bad_setup;
    logic               last_comp;
    logic               load_out;

    assign cm        = cnt_reg - 5'd3;
    assign sidx      = cm[4:1];
    assign ph        = cm[0];
    assign ord_rd    = cnt_reg[1:0] - 2'd1;
    assign ord_cap   = cnt_reg[1:0] - 2'd2;
    assign is_first  = (j_reg == pm_rd_reg[7:4]);
    assign is_second = !is_first && (j_reg == pm_rd_reg[3:0]);
    assign is_other  = !is_first && !is_second;
    assign fa_s      = {8'd0, fa_reg};
    assign fb_s      = {8'd0, fb_reg};
    assign d33       = fa_s - fb_s;
    assign om33      = ONE_S - fa_s;
    assign sh8       = prod_reg >>> 8;
    assign sh24      = prod_reg >>> 24;
    assign cap_val   = (is_second && ord_cap[0]) ? -sx32(coef_rd_reg) : sx32(coef_rd_reg);
    assign fin_sum   = hi_reg + {32'd0, prod_reg[63:32]};
    assign bad_setup = (cin_reg < 5'd2) || (cin_reg > 5'(MAX_COMPONENTS))
                    || (pin_reg < 7'd1) || (pin_reg > 7'(MAX_PAIRS));
    assign last_comp = ((5'(j_reg) + 5'd1) == cin_reg);
    assign load_out  = ((state_reg == S_EMIT) || (state_reg == S_BAD))
                    && (!m_valid_reg || m_ready);
    assign q_pop     = (state_reg == S_IDLE) && !q_status.empty;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        if (acc_reg > MAX32) begin
            ld_sat = 32'h7fffffff;
        end else if (acc_reg < MIN32) begin
            ld_sat = 32'h80000000;
        end else begin
            ld_sat = acc_reg[31:0];
        end
    end

    always_comb begin
        unique case (sidx)
            4'd3:    tgt = is_other ? 3'd4 : 3'd3;
            4'd4:    tgt = is_other ? 3'd5 : 3'd4;
            4'd5:    tgt = is_other ? 3'd6 : 3'd5;
            4'd6:    tgt = is_other ? 3'd3 : 3'd6;
            default: tgt = sidx[2:0];
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        opa = '0;
        opb = '0;
        unique case (state_reg)
            S_LD0: begin
                opa = sx32(cmd_reg.item.coef_s);
                opb = {13'd0, temp_reg};
            end
            S_LD1: begin
                opa = sx32(cmd_reg.item.coef_cp);
                opb = {1'b0, tlt_reg};
            end
            S_LD2: begin
                opa = sx32(cmd_reg.item.coef_v);
                opb = {9'd0, press_reg};
            end
            S_PAIR: begin
                if (cnt_reg >= 5'd3 && !ph) begin
                    case (sidx)
                        4'd0: begin
                            opa = is_other ? fa_s : om33;
                            opb = is_other ? fb_s : d33;
                        end
                        4'd1: begin
                            opa = is_other ? d33 : fb_s;
                            opb = d33;
                        end
                        4'd2: begin
                            opa = sx29(r_reg[1]);
                            opb = d33;
                        end
                        4'd3: begin
                            opa = is_other ? (d33 <<< 1) : fb_s;
                            opb = is_other ? sx29(r_reg[0]) : om33;
                        end
                        4'd4: begin
                            opa = is_other ? ((sx29(r_reg[1]) <<< 1) + sx29(r_reg[1])) : fb_s;
                            opb = is_other ? sx29(r_reg[0])
                                           : ((sx29(r_reg[0]) <<< 1) + fb_s);
                        end
                        4'd5: begin
                            opa = is_other ? (sx29(r_reg[2]) <<< 2) : sx29(r_reg[1]);
                            opb = is_other ? sx29(r_reg[0])
                                           : ((sx29(r_reg[0]) <<< 1) + sx29(r_reg[0])
                                              + (fb_s <<< 1));
                        end
                        4'd6: begin
                            opa = is_other ? sx29(r_reg[0]) : sx29(r_reg[2]);
                            opb = is_other ? ONE_S
                                           : ((sx29(r_reg[0]) <<< 2) + (fb_s <<< 1) + fb_s);
                        end
                        4'd7: begin
                            opa = c_reg[0];
                            opb = sx29(r_reg[3]);
                        end
                        4'd8: begin
                            opa = c_reg[1];
                            opb = sx29(r_reg[4]);
                        end
                        4'd9: begin
                            opa = c_reg[2];
                            opb = sx29(r_reg[5]);
                        end
                        4'd10: begin
                            opa = c_reg[3];
                            opb = sx29(r_reg[6]);
                        end
                        default: begin
                            opa = '0;
                            opb = '0;
                        end
                    endcase
                end
            end
            S_FIN1: begin
                opa = {1'b0, mag_reg[63:32]};
                opb = {1'b0, irt_reg};
            end
            S_FIN2: begin
                opa = {1'b0, mag_reg[31:0]};
                opb = {1'b0, irt_reg};
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_reg  <= 20'd76800;
            tlt_reg   <= 32'd437016;
            press_reg <= 24'd256;
            irt_reg   <= 32'd1731765;
            cin_reg   <= 5'd2;
            pin_reg   <= 7'd1;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_TEMP:  temp_reg  <= cfg_wdata[19:0];
                REG_TLT:   tlt_reg   <= cfg_wdata;
                REG_PRESS: press_reg <= cfg_wdata[23:0];
                REG_IRT:   irt_reg   <= cfg_wdata;
                REG_COMPS: cin_reg   <= cfg_wdata[4:0];
                REG_PAIRS: pin_reg   <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            ip_reg      <= '0;
            j_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_pop) begin
                        state_reg <= S_DISP;
                    end
                end
                S_DISP: begin
                    unique case (cmd_reg.op)
                        MODE_COEF: state_reg <= S_LD0;
                        MODE_FRAC: state_reg <= S_FRW;
                        MODE_COMP: begin
                            j_reg   <= '0;
                            ip_reg  <= '0;
                            cnt_reg <= '0;
                            state_reg <= bad_setup ? S_BAD : S_PAIR;
                        end
                        default: state_reg <= S_IDLE;
                    endcase
                end
                S_LD0: state_reg <= S_LD1;
                S_LD1: state_reg <= S_LD2;
                S_LD2: state_reg <= S_LD3;
                S_LD3: state_reg <= S_LD4;
                S_LD4: state_reg <= S_IDLE;
                S_FRW: state_reg <= S_IDLE;
                S_BAD: begin
                    if (load_out) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_PAIR: begin
                    if (cnt_reg == CNT_LAST) begin
                        cnt_reg <= '0;
                        if ((7'(ip_reg) + 7'd1) == pin_reg) begin
                            state_reg <= S_FIN0;
                        end else begin
                            ip_reg <= ip_reg + 1'b1;
                        end
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_FIN0: state_reg <= S_FIN1;
                S_FIN1: state_reg <= S_FIN2;
                S_FIN2: state_reg <= S_FIN3;
                S_FIN3: state_reg <= S_EMIT;
                S_EMIT: begin
                    if (load_out) begin
                        if (last_comp) begin
                            state_reg <= S_IDLE;
                        end else begin
                            j_reg     <= j_reg + 1'b1;
                            ip_reg    <= '0;
                            cnt_reg   <= '0;
                            state_reg <= S_PAIR;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg <= q_head;
        end
        prod_reg <= opa * opb;
        case (state_reg)
            S_DISP: acc_reg <= '0;
            S_LD0:  acc_reg <= {{32{cmd_reg.item.coef_u[31]}}, cmd_reg.item.coef_u};
            S_LD1, S_LD2, S_LD3: acc_reg <= acc_reg + sh8[63:0];
            S_PAIR: begin
                if (cnt_reg == 5'd2) begin
                    fa_reg <= is_second ? fr2_rd_reg : fr1_rd_reg;
                    fb_reg <= is_second ? fr1_rd_reg : fr2_rd_reg;
                end
                if (cnt_reg >= 5'd2 && cnt_reg <= 5'd5) begin
                    c_reg[ord_cap] <= cap_val;
                end
                if (cnt_reg >= 5'd3 && ph) begin
                    if (sidx < 4'd7) begin
                        r_reg[tgt] <= sh24[28:0];
                    end else if (is_other) begin
                        acc_reg <= acc_reg - sh8[63:0];
                    end else begin
                        acc_reg <= acc_reg + sh8[63:0];
                    end
                end
            end
            S_FIN0: begin
                neg_reg <= acc_reg[63];
                mag_reg <= acc_reg[63] ? 64'(-acc_reg) : 64'(acc_reg);
            end
            S_FIN2: hi_reg <= prod_reg[63:0];
            S_FIN3: begin
                if (!neg_reg) begin
                    if (fin_sum > 64'd2147483647) begin
                        res_reg <= 32'h7fffffff;
                        rst_reg <= ST_SAT;
                    end else begin
                        res_reg <= fin_sum[31:0];
                        rst_reg <= ST_OK;
                    end
                end else begin
                    if (fin_sum > 64'd2147483648) begin
                        res_reg <= 32'h80000000;
                        rst_reg <= ST_SAT;
                    end else begin
                        res_reg <= -fin_sum[31:0];
                        rst_reg <= ST_OK;
                    end
                end
            end
            S_EMIT: begin
                if (load_out) begin
                    acc_reg <= '0;
                    m_data_reg.result_component <= j_reg;
                    m_data_reg.ln_gamma         <= res_reg;
                    m_data_reg.status           <= rst_reg;
                    m_data_reg.last             <= last_comp;
                end
            end
            S_BAD: begin
                if (load_out) begin
                    m_data_reg.result_component <= '0;
                    m_data_reg.ln_gamma         <= '0;
                    m_data_reg.status           <= ST_BAD;
                    m_data_reg.last             <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    // stores
    always_ff @(posedge aclk) begin
        if (state_reg == S_LD4) begin
            coef_mem[{cmd_reg.item.pair_entry, cmd_reg.item.poly_order}] <= ld_sat;
            pm_mem[cmd_reg.item.pair_entry] <= {cmd_reg.item.comp_first,
                                                cmd_reg.item.comp_second};
        end
        if (state_reg == S_FRW) begin
            fr_mem[cmd_reg.item.component] <= cmd_reg.item.fraction;
        end
        coef_rd_reg <= coef_mem[{ip_reg, ord_rd}];
        pm_rd_reg   <= pm_mem[ip_reg];
        fr1_rd_reg  <= fr_mem[pm_rd_reg[7:4]];
        fr2_rd_reg  <= fr_mem[pm_rd_reg[3:0]];
    end

    a_pair_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PAIR) |-> (({1'b0, ip_reg} < pin_reg) && ({1'b0, j_reg} < cin_reg)))
        else $error("pair walk out of range");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_LAST)
        else $error("step counter overrun");

    a_bad_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.status == ST_BAD) |-> m_data_reg.last)
        else $error("bad setup result not marked last");

    a_pop_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (state_reg == S_DISP))
        else $error("popped request not dispatched");

    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_valid_reg)
        else $error("result lost at output register");

endmodule
